// ===== hdl/isrp_pkg.sv =====
// Shared constants and types for the sensor-hub report parser.
// Used by the front end, the command queue, the back end, the top level and the testbench.
`default_nettype none
package isrp_pkg;

  localparam int unsigned MAX_PAYLOAD = 64;
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QAW = $clog2(QDEPTH);

  localparam logic [7:0] ID_TS_A = 8'hFB;
  localparam logic [7:0] ID_TS_B = 8'hFA;
  localparam logic [7:0] ID_ROT = 8'h05;
  localparam logic [7:0] ID_ACC = 8'h01;
  localparam logic [7:0] ID_GYR = 8'h02;
  localparam logic [7:0] CHAN_A = 8'd3;
  localparam logic [7:0] CHAN_B = 8'd4;

  localparam logic [3:0] ROT_BYTES = 4'd14;
  localparam logic [3:0] MOT_BYTES = 4'd10;
  localparam logic [3:0] TS_LEFT = 4'd4;
  localparam logic [14:0] LEN_MIN = 15'd4;
  localparam logic [14:0] LEN_MAX = 15'd512;
  localparam logic [9:0] HDR_BYTES = 10'd4;

  localparam logic [1:0] KIND_SKIP = 2'd0;
  localparam logic [1:0] KIND_ROT = 2'd1;
  localparam logic [1:0] KIND_ACC = 2'd2;
  localparam logic [1:0] KIND_GYR = 2'd3;

  localparam logic [1:0] FIN_ROT = 2'd0;
  localparam logic [1:0] FIN_ACC = 2'd1;
  localparam logic [1:0] FIN_GYR = 2'd2;
  localparam logic [1:0] FIN_REJ = 2'd3;

  localparam logic [1:0] UPD_ORIENT = 2'd0;
  localparam logic [1:0] UPD_MOTION = 2'd1;
  localparam logic [1:0] UPD_REJECT = 2'd2;

  typedef struct packed {
    logic       wr;
    logic [2:0] slot;
    logic [7:0] data;
    logic       fin;
    logic [1:0] fin_kind;
  } cmd_t;

endpackage
`default_nettype wire

// ===== hdl/isrp_in_if.sv =====
// Byte channel into the parser: valid/ready handshake with one packet byte per beat.
// Standalone interface, no package dependency.
`default_nettype none
interface isrp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;

  modport source (output valid, output data_byte, output first_byte, input ready);
  modport sink (input valid, input data_byte, input first_byte, output ready);
endinterface
`default_nettype wire

// ===== hdl/isrp_out_if.sv =====
// Result channel out of the parser: valid/ready handshake with one snapshot per beat.
// Standalone interface, no package dependency.
`default_nettype none
interface isrp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         update_kind;
  logic signed [15:0] quat_i;
  logic signed [15:0] quat_j;
  logic signed [15:0] quat_k;
  logic signed [15:0] quat_real;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] gyro_x;
  logic signed [15:0] gyro_y;
  logic signed [15:0] gyro_z;
  logic [1:0]         motion_valid;

  modport source (output valid, output update_kind, output quat_i, output quat_j,
                  output quat_k, output quat_real, output accel_x, output accel_y,
                  output accel_z, output gyro_x, output gyro_y, output gyro_z,
                  output motion_valid, input ready);
  modport sink (input valid, input update_kind, input quat_i, input quat_j,
                input quat_k, input quat_real, input accel_x, input accel_y,
                input accel_z, input gyro_x, input gyro_y, input gyro_z,
                input motion_valid, output ready);
endinterface
`default_nettype wire

// ===== hdl/isrp_front.sv =====
// Front end: header decode, packet framing and report classification per byte.
// Emits assembly and commit commands of type isrp_pkg::cmd_t; depends on isrp_pkg.
`default_nettype none
module isrp_front (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         accept,
  input  wire logic [7:0]   data_byte,
  input  wire logic         first_byte,
  output logic              push,
  output isrp_pkg::cmd_t    cmd
);
  import isrp_pkg::*;

  logic [9:0] byte_index, byte_index_next;
  logic [9:0] packet_length, packet_length_next;
  logic       packet_live, packet_live_next;
  logic       channel_ok, channel_ok_next;
  logic [1:0] report_kind, report_kind_next;
  logic [3:0] report_left, report_left_next;

  logic [9:0]  e_idx, e_len;
  logic        e_live, e_chok;
  logic [1:0]  e_kind;
  logic [3:0]  e_left;
  logic [14:0] total;
  logic [9:0]  remain;
  logic [3:0]  rep_bytes, pos;
  logic [9:0]  idx_inc;

  always_comb begin
    e_live = first_byte | packet_live;
    e_idx = first_byte ? 10'd0 : byte_index;
    e_len = first_byte ? 10'd0 : packet_length;
    e_chok = first_byte ? 1'b0 : channel_ok;
    e_kind = first_byte ? KIND_SKIP : report_kind;
    e_left = first_byte ? 4'd0 : report_left;

    byte_index_next = e_idx;
    packet_length_next = e_len;
    packet_live_next = e_live;
    channel_ok_next = e_chok;
    report_kind_next = e_kind;
    report_left_next = e_left;

    total = {data_byte[6:0], e_len[7:0]};
    remain = e_len - e_idx;
    rep_bytes = (e_kind == KIND_ROT) ? ROT_BYTES : MOT_BYTES;
    pos = rep_bytes - e_left;
    idx_inc = e_idx + 10'd1;

    push = 1'b0;
    cmd = '0;
    cmd.data = data_byte;

    if (e_live) begin
      byte_index_next = idx_inc;
      if (e_idx < HDR_BYTES) begin
        unique case (e_idx[1:0])
          2'd0: packet_length_next = {2'b00, data_byte};
          2'd1: packet_length_next = (total < LEN_MIN || total > LEN_MAX) ? 10'd0
                                                                       : total[9:0];
          2'd2: channel_ok_next = (data_byte == CHAN_A) || (data_byte == CHAN_B);
          2'd3: begin
            if (e_len <= HDR_BYTES || (e_len - HDR_BYTES) > 10'(MAX_PAYLOAD)) begin
              packet_live_next = 1'b0;
              push = 1'b1;
              cmd.fin = 1'b1;
              cmd.fin_kind = FIN_REJ;
            end
          end
          default: ;
        endcase
      end else begin
        if (e_chok) begin
          if (e_left != 4'd0) begin
            if (e_kind != KIND_SKIP && pos >= 4'd4 && pos <= 4'd11) begin
              cmd.wr = 1'b1;
              cmd.slot = 3'(pos - 4'd4);
            end
            report_left_next = e_left - 4'd1;
            if (e_left == 4'd1 && e_kind != KIND_SKIP) begin
              cmd.fin = 1'b1;
              unique case (e_kind)
                KIND_ROT: cmd.fin_kind = FIN_ROT;
                KIND_ACC: cmd.fin_kind = FIN_ACC;
                default:  cmd.fin_kind = FIN_GYR;
              endcase
              report_kind_next = KIND_SKIP;
            end
            push = cmd.wr | cmd.fin;
          end else begin
            if (data_byte == ID_TS_A || data_byte == ID_TS_B) begin
              report_kind_next = KIND_SKIP;
              report_left_next = TS_LEFT;
            end else if (data_byte == ID_ROT && remain >= 10'(ROT_BYTES)) begin
              report_kind_next = KIND_ROT;
              report_left_next = ROT_BYTES - 4'd1;
            end else if (data_byte == ID_ACC && remain >= 10'(MOT_BYTES)) begin
              report_kind_next = KIND_ACC;
              report_left_next = MOT_BYTES - 4'd1;
            end else if (data_byte == ID_GYR && remain >= 10'(MOT_BYTES)) begin
              report_kind_next = KIND_GYR;
              report_left_next = MOT_BYTES - 4'd1;
            end
          end
        end
        if (idx_inc >= e_len) begin
          packet_live_next = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index <= '0;
      packet_length <= '0;
      packet_live <= 1'b0;
      channel_ok <= 1'b0;
      report_kind <= KIND_SKIP;
      report_left <= '0;
    end else if (accept) begin
      byte_index <= byte_index_next;
      packet_length <= packet_length_next;
      packet_live <= packet_live_next;
      channel_ok <= channel_ok_next;
      report_kind <= report_kind_next;
      report_left <= report_left_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/isrp_queue.sv =====
// Short command queue between the front end and the back end.
// Holds isrp_pkg::cmd_t entries, QDEPTH deep; depends on isrp_pkg.
`default_nettype none
module isrp_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire isrp_pkg::cmd_t  push_cmd,
  output logic                 full,
  input  wire logic            pop,
  output logic                 head_valid,
  output isrp_pkg::cmd_t       head_cmd
);
  import isrp_pkg::*;

  cmd_t         slots [QDEPTH];
  logic [QAW-1:0] wr_ptr;
  logic [QAW-1:0] rd_ptr;
  logic [QAW:0]   count;

  assign full = (count == (QAW+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_cmd = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + (QAW+1)'(push) - (QAW+1)'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/isrp_back.sv =====
// Back end: report byte assembly, stored sensor values and the result register.
// Consumes isrp_pkg::cmd_t from the queue; depends on isrp_pkg.
`default_nettype none
module isrp_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            head_valid,
  input  wire isrp_pkg::cmd_t  head_cmd,
  output logic                 pop,
  isrp_out_if.source           out_ch
);
  import isrp_pkg::*;

  logic [7:0]         asm_bytes [8];
  logic [7:0]         asm_next [8];
  logic signed [15:0] quat [4];
  logic signed [15:0] accel [3];
  logic signed [15:0] gyro [3];
  logic [1:0]         valid_marks;
  logic               out_valid;
  logic [1:0]         out_kind;

  assign pop = head_valid && (!head_cmd.fin || !out_valid || out_ch.ready);

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      asm_next[i] = asm_bytes[i];
    end
    if (head_cmd.wr) begin
      asm_next[head_cmd.slot] = head_cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && head_cmd.wr) begin
      asm_bytes[head_cmd.slot] <= head_cmd.data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 4; i++) begin
        quat[i] <= '0;
      end
      for (int i = 0; i < 3; i++) begin
        accel[i] <= '0;
        gyro[i] <= '0;
      end
      valid_marks <= '0;
      out_valid <= 1'b0;
      out_kind <= UPD_ORIENT;
    end else begin
      if (out_valid && out_ch.ready) begin
        out_valid <= 1'b0;
      end
      if (pop && head_cmd.fin) begin
        out_valid <= 1'b1;
        unique case (head_cmd.fin_kind)
          FIN_ROT: begin
            for (int i = 0; i < 4; i++) begin
              quat[i] <= {asm_next[2*i+1], asm_next[2*i]};
            end
            out_kind <= UPD_ORIENT;
          end
          FIN_ACC: begin
            for (int i = 0; i < 3; i++) begin
              accel[i] <= {asm_next[2*i+1], asm_next[2*i]};
            end
            valid_marks[0] <= 1'b1;
            out_kind <= UPD_MOTION;
          end
          FIN_GYR: begin
            for (int i = 0; i < 3; i++) begin
              gyro[i] <= {asm_next[2*i+1], asm_next[2*i]};
            end
            valid_marks[1] <= 1'b1;
            out_kind <= UPD_MOTION;
          end
          default: out_kind <= UPD_REJECT;
        endcase
      end
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.update_kind = out_kind;
  assign out_ch.quat_i = quat[0];
  assign out_ch.quat_j = quat[1];
  assign out_ch.quat_k = quat[2];
  assign out_ch.quat_real = quat[3];
  assign out_ch.accel_x = accel[0];
  assign out_ch.accel_y = accel[1];
  assign out_ch.accel_z = accel[2];
  assign out_ch.gyro_x = gyro[0];
  assign out_ch.gyro_y = gyro[1];
  assign out_ch.gyro_z = gyro[2];
  assign out_ch.motion_valid = valid_marks;

endmodule
`default_nettype wire

// ===== hdl/imu_sensor_report_parser_unit.sv =====
// Sensor-hub report parser: bytes of a packet go in on in_ch, one per beat, with
// first_byte set on the first header byte. Each completed rotation, acceleration or
// angular-rate report, and each packet rejected at its fourth header byte, gives one
// beat on out_ch carrying update_kind and a snapshot of every stored value.
// Throughput is one byte per cycle while the command queue has room. A result is offered
// on out_ch once the back end pops the command of the byte completing it: the front end
// decodes that byte in the same cycle and writes its command into the queue at the
// accepting edge, and the back end loads its result register as it pops that command.
// A four-entry command queue sits between front and back end; in_ch.ready falls only
// when it is full, which happens only when out_ch is held off while results keep
// arriving. Bytes that produce no command still need a free queue slot to be taken.
// The result register holds its beat until out_ch.ready.
// Reset (rst, synchronous) closes any open packet, empties the queue and clears the
// stored quaternion, motion values and their valid marks to zero.
// Files: isrp_pkg, isrp_in_if, isrp_out_if, isrp_front, isrp_queue, isrp_back.
`default_nettype none
module imu_sensor_report_parser_unit (
  input  wire logic   clk,
  input  wire logic   rst,
  isrp_in_if.sink     in_ch,
  isrp_out_if.source  out_ch
);
  import isrp_pkg::*;

  logic accept;
  logic push;
  cmd_t push_cmd;
  logic q_full;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && !q_full;

  isrp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (in_ch.data_byte),
    .first_byte (in_ch.first_byte),
    .push       (push),
    .cmd        (push_cmd)
  );

  isrp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push && accept),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  isrp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head_cmd   (head_cmd),
    .pop        (pop),
    .out_ch     (out_ch)
  );

endmodule
`default_nettype wire

// ===== hdl/isrp_checker.sv =====
// Port-level checks for the report parser, bound to the top level.
// Depends only on the top level's clock, reset and out_ch signals.
`default_nettype none
module isrp_port_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_kind,
  input wire logic [1:0] out_motion
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_motion))
    else $error("result beat changed while stalled");

  a_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> out_kind != 2'd3)
    else $error("result carries an undefined update kind");

  a_marks: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready |=> !out_valid || ((out_motion & $past(out_motion)) ==
                                              $past(out_motion)))
    else $error("motion valid mark was lost between results");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result shown right after reset");

endmodule

bind imu_sensor_report_parser_unit isrp_port_checker u_isrp_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_kind   (out_ch.update_kind),
  .out_motion (out_ch.motion_valid)
);
`default_nettype wire

// ===== dv/isrp_checker.sv =====
// Checker for the sensor-hub report parser: watches both channels, decodes every
// accepted byte into the expected snapshots and compares each result beat field by field.
// Depends on isrp_pkg, isrp_in_if and isrp_out_if.
module isrp_checker (
  input  wire logic clk,
  input  wire logic rst,
  isrp_in_if        in_ch,
  isrp_out_if       out_ch,
  output int        errors,
  output int        waiting,
  output int        orient_count,
  output int        motion_count,
  output int        reject_count
);
  import isrp_pkg::*;

  // Element 0 is update_kind, 1..4 the quaternion, 5..7 acceleration,
  // 8..10 angular rate and 11 the valid marks.
  typedef logic [11:0][15:0] snapshot_t;

  logic        in_packet;
  logic [9:0]  byte_pos;
  logic [9:0]  pkt_len;
  logic        chan_parsed;
  logic [1:0]  rpt_kind;
  logic [3:0]  rpt_left;
  logic [63:0] rpt_words;
  logic [15:0] quat [4];
  logic [15:0] accel [3];
  logic [15:0] gyro [3];
  logic [1:0]  seen_marks;
  snapshot_t   expected_snaps [$];

  function automatic string field_label(input int idx);
    case (idx)
      0: return "update_kind";
      1: return "quat_i";
      2: return "quat_j";
      3: return "quat_k";
      4: return "quat_real";
      5: return "accel_x";
      6: return "accel_y";
      7: return "accel_z";
      8: return "gyro_x";
      9: return "gyro_y";
      10: return "gyro_z";
      default: return "motion_valid";
    endcase
  endfunction

  function automatic snapshot_t stored_snapshot(input logic [1:0] kind);
    return {{14'd0, seen_marks}, gyro[2], gyro[1], gyro[0], accel[2], accel[1], accel[0],
            quat[3], quat[2], quat[1], quat[0], {14'd0, kind}};
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < 50) begin
      $display("[%0t] mismatch: %s", $time, msg);
    end
    errors++;
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic first);
    logic [14:0] total;
    logic [9:0]  remain;
    logic [3:0]  pos;
    if (first) begin
      in_packet = 1'b1;
      byte_pos = '0;
      pkt_len = '0;
      chan_parsed = 1'b0;
      rpt_kind = KIND_SKIP;
      rpt_left = '0;
      rpt_words = '0;
    end
    if (in_packet && byte_pos < HDR_BYTES) begin
      case (byte_pos)
        10'd0: pkt_len = {2'b00, b};
        10'd1: begin
          total = {b[6:0], pkt_len[7:0]};
          pkt_len = (total < LEN_MIN || total > LEN_MAX) ? 10'd0 : total[9:0];
        end
        10'd2: chan_parsed = (b == CHAN_A || b == CHAN_B);
        default: ;
      endcase
      if (byte_pos == 10'd3 &&
          (pkt_len <= HDR_BYTES || 32'(pkt_len - HDR_BYTES) > MAX_PAYLOAD)) begin
        in_packet = 1'b0;
        expected_snaps.push_back(stored_snapshot(UPD_REJECT));
      end else begin
        byte_pos++;
      end
    end else if (in_packet) begin
      if (chan_parsed) begin
        if (rpt_left != 4'd0) begin
          if (rpt_kind != KIND_SKIP) begin
            pos = ((rpt_kind == KIND_ROT) ? ROT_BYTES : MOT_BYTES) - rpt_left;
            if (pos >= 4'd4 && pos <= 4'd11) begin
              rpt_words[8 * (pos - 4'd4) +: 8] = b;
            end
          end
          rpt_left--;
          if (rpt_left == 4'd0 && rpt_kind != KIND_SKIP) begin
            if (rpt_kind == KIND_ROT) begin
              for (int k = 0; k < 4; k++) quat[k] = rpt_words[16 * k +: 16];
              expected_snaps.push_back(stored_snapshot(UPD_ORIENT));
            end else if (rpt_kind == KIND_ACC) begin
              for (int k = 0; k < 3; k++) accel[k] = rpt_words[16 * k +: 16];
              seen_marks[0] = 1'b1;
              expected_snaps.push_back(stored_snapshot(UPD_MOTION));
            end else begin
              for (int k = 0; k < 3; k++) gyro[k] = rpt_words[16 * k +: 16];
              seen_marks[1] = 1'b1;
              expected_snaps.push_back(stored_snapshot(UPD_MOTION));
            end
            rpt_kind = KIND_SKIP;
          end
        end else begin
          // Payload bytes still left in the packet, the id byte included.
          remain = pkt_len - byte_pos;
          rpt_words = '0;
          if (b == ID_TS_A || b == ID_TS_B) begin
            rpt_kind = KIND_SKIP;
            rpt_left = TS_LEFT;
          end else if (b == ID_ROT && remain >= ROT_BYTES) begin
            rpt_kind = KIND_ROT;
            rpt_left = ROT_BYTES - 4'd1;
          end else if (b == ID_ACC && remain >= MOT_BYTES) begin
            rpt_kind = KIND_ACC;
            rpt_left = MOT_BYTES - 4'd1;
          end else if (b == ID_GYR && remain >= MOT_BYTES) begin
            rpt_kind = KIND_GYR;
            rpt_left = MOT_BYTES - 4'd1;
          end
        end
      end
      byte_pos++;
      if (byte_pos >= pkt_len) in_packet = 1'b0;
    end
  endtask

  always @(posedge clk) begin
    snapshot_t seen_snap;
    snapshot_t want_snap;
    if (rst) begin
      in_packet = 1'b0;
      byte_pos = '0;
      pkt_len = '0;
      chan_parsed = 1'b0;
      rpt_kind = KIND_SKIP;
      rpt_left = '0;
      rpt_words = '0;
      foreach (quat[k]) quat[k] = '0;
      foreach (accel[k]) accel[k] = '0;
      foreach (gyro[k]) gyro[k] = '0;
      seen_marks = '0;
      expected_snaps.delete();
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        decode_byte(in_ch.data_byte, in_ch.first_byte);
      end
      if (out_ch.valid && out_ch.ready) begin
        seen_snap = {{14'd0, out_ch.motion_valid}, out_ch.gyro_z, out_ch.gyro_y, out_ch.gyro_x,
                     out_ch.accel_z, out_ch.accel_y, out_ch.accel_x, out_ch.quat_real,
                     out_ch.quat_k, out_ch.quat_j, out_ch.quat_i, {14'd0, out_ch.update_kind}};
        if (expected_snaps.size() == 0) begin
          report_mismatch($sformatf("result beat of kind %0d with nothing expected",
                                    out_ch.update_kind));
        end else begin
          want_snap = expected_snaps.pop_front();
          for (int f = 0; f < 12; f++) begin
            if (seen_snap[f] !== want_snap[f]) begin
              report_mismatch($sformatf("%s is %h, expected %h", field_label(f),
                                        seen_snap[f], want_snap[f]));
            end
          end
          case (want_snap[0][1:0])
            UPD_ORIENT: orient_count++;
            UPD_MOTION: motion_count++;
            default: reject_count++;
          endcase
        end
      end
    end
    waiting = expected_snaps.size();
  end
endmodule

// ===== dv/testbench.sv =====
// Top of the parser testbench: clock, reset, byte stimulus, result back-pressure,
// watchdog and verdict. Depends on isrp_pkg, both channel interfaces, isrp_checker
// and imu_sensor_report_parser_unit.
module testbench;
  import isrp_pkg::*;

  localparam int ITEMS = 1550;
  localparam int QUIET_LIMIT = 2000;
  localparam int LONG_STALL = 100;

  logic clk = 1'b0;
  logic rst = 1'b1;

  isrp_in_if  in_ch ();
  isrp_out_if out_ch ();

  int mismatches;
  int outstanding;
  int orient_count;
  int motion_count;
  int reject_count;
  int counted_bytes = 0;
  int stall_requests = 0;
  bit tx_gaps_on = 1'b1;
  logic [7:0] payload [$];

  imu_sensor_report_parser_unit i_dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch)
  );

  isrp_checker i_check (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .errors(mismatches),
    .waiting(outstanding),
    .orient_count(orient_count),
    .motion_count(motion_count),
    .reject_count(reject_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task automatic send_byte(input logic [7:0] b, input logic first);
    int gap;
    int r;
    gap = 0;
    if (tx_gaps_on) begin
      r = $urandom_range(0, 99);
      if (r >= 96) gap = $urandom_range(6, 25);
      else if (r >= 70) gap = $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.first_byte <= first;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_loose(input int n);
    logic [7:0] b;
    repeat (n) begin
      b = 8'($urandom);
      send_byte(b, 1'b0);
    end
  endtask

  task automatic put_report(input logic [7:0] id, input logic [63:0] body);
    int n;
    logic [7:0] filler;
    case (id)
      ID_ROT: n = 14;
      ID_ACC, ID_GYR: n = 10;
      ID_TS_A, ID_TS_B: n = 5;
      default: n = 1;
    endcase
    payload.push_back(id);
    for (int i = 1; i < n; i++) begin
      filler = 8'($urandom);
      payload.push_back((i >= 4 && i <= 11) ? body[8 * (i - 4) +: 8] : filler);
    end
  endtask

  task automatic ship(input logic [14:0] len, input logic [7:0] chan);
    logic hi_bit;
    logic [7:0] seq;
    hi_bit = 1'($urandom_range(0, 1));
    seq = 8'($urandom);
    send_byte(len[7:0], 1'b1);
    send_byte({hi_bit, len[14:8]}, 1'b0);
    send_byte(chan, 1'b0);
    send_byte(seq, 1'b0);
    foreach (payload[i]) send_byte(payload[i], 1'b0);
    counted_bytes += 4 + payload.size();
  endtask

  // Appends reports until the payload reaches budget; a timestamp may run past it.
  task automatic fill_reports(input int budget);
    int room;
    int r;
    logic [7:0] b;
    while (payload.size() < budget) begin
      room = budget - payload.size();
      r = $urandom_range(0, 99);
      if (r < 30 && room >= 14) put_report(ID_ROT, {$urandom, $urandom});
      else if (r < 55 && room >= 10) put_report(ID_ACC, {$urandom, $urandom});
      else if (r < 80 && room >= 10) put_report(ID_GYR, {$urandom, $urandom});
      else if (r < 88) put_report(r[0] ? ID_TS_A : ID_TS_B, {$urandom, $urandom});
      else if (r < 94) begin
        case (r % 3)
          0: payload.push_back(ID_ROT);
          1: payload.push_back(ID_ACC);
          default: payload.push_back(ID_GYR);
        endcase
      end else begin
        b = 8'($urandom);
        payload.push_back(b);
      end
    end
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // The result side holds off while back-to-back motion reports keep coming.
  task automatic flood_while_stalled();
    bit saved_gaps;
    saved_gaps = tx_gaps_on;
    tx_gaps_on = 1'b0;
    stall_requests <= stall_requests + 1;
    repeat (2) begin
      payload.delete();
      repeat (6) put_report($urandom_range(0, 1) ? ID_ACC : ID_GYR, {$urandom, $urandom});
      ship(15'(payload.size() + 4), CHAN_A);
    end
    tx_gaps_on = saved_gaps;
  endtask

  task automatic random_packet();
    int r;
    int budget;
    int keep;
    logic [14:0] len;
    logic [7:0] chan;
    r = $urandom_range(0, 99);
    payload.delete();
    budget = ($urandom_range(0, 3) == 0) ? MAX_PAYLOAD : $urandom_range(1, 40);
    chan = $urandom_range(0, 1) ? CHAN_A : CHAN_B;
    if (r < 66) begin
      fill_reports(budget);
      ship(15'(budget + 4), chan);
    end else if (r < 74) begin
      case ($urandom_range(0, 3))
        0: len = 15'($urandom_range(0, 3));
        1: len = 15'd4;
        2: len = 15'($urandom_range(MAX_PAYLOAD + 5, 512));
        default: len = 15'($urandom_range(513, 32767));
      endcase
      chan = 8'($urandom);
      ship(len, chan);
      send_loose($urandom_range(0, 6));
    end else if (r < 82) begin
      fill_reports(budget);
      chan = 8'($urandom);
      if (chan == CHAN_A || chan == CHAN_B) chan = ~chan;
      ship(15'(budget + 4), chan);
    end else if (r < 90) begin
      fill_reports(budget);
      keep = $urandom_range(0, budget - 1);
      while (payload.size() > keep) void'(payload.pop_back());
      ship(15'(budget + 4), chan);
    end else if (r < 96) begin
      repeat (budget) payload.push_back(8'($urandom));
      ship(15'(budget + 4), chan);
    end else begin
      send_loose($urandom_range(1, 4));
    end
  endtask

  initial begin : result_sink
    int stall_left;
    int stalls_served;
    int cyc;
    int r;
    bit rx_gaps_on;
    out_ch.ready = 1'b0;
    stall_left = 0;
    stalls_served = 0;
    cyc = 0;
    rx_gaps_on = 1'b1;
    forever begin
      @(negedge clk);
      cyc++;
      if (cyc % 250 == 0) rx_gaps_on = ($urandom_range(0, 3) != 0);
      if (stalls_served != stall_requests) begin
        stalls_served = stall_requests;
        stall_left = LONG_STALL;
      end else if (stall_left == 0 && rx_gaps_on) begin
        r = $urandom_range(0, 99);
        if (r < 20) stall_left = $urandom_range(1, 3);
        else if (r < 23) stall_left = $urandom_range(10, 40);
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
      else quiet++;
    end
    $display("Watchdog: no beat on either channel for %0d cycles.", QUIET_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin : stimulus
    int stop_at;
    bit mid_flood_done;
    in_ch.valid = 1'b0;
    in_ch.data_byte = '0;
    in_ch.first_byte = 1'b0;
    mid_flood_done = 1'b0;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    payload.delete();
    put_report(ID_ROT, 64'h7FFF_8000_FFFF_0000);
    ship(18, CHAN_A);
    payload.delete();
    put_report(ID_GYR, 64'h0000_0000_8000_7FFF);
    ship(14, CHAN_B);
    payload.delete();
    put_report(ID_ACC, 64'h0000_7FFF_8000_FFFF);
    ship(14, CHAN_A);
    payload.delete();
    put_report(ID_TS_A, '0);
    put_report(ID_TS_B, '1);
    put_report(ID_ROT, {$urandom, $urandom});
    ship(15'(payload.size() + 4), CHAN_B);

    // Rejected headers: short, empty, oversized and too much payload.
    payload.delete();
    ship(0, CHAN_A);
    ship(3, CHAN_A);
    ship(4, CHAN_B);
    send_loose(2);
    ship(15'(MAX_PAYLOAD + 5), CHAN_A);
    ship(512, 8'hFF);
    ship(513, CHAN_B);
    ship(15'h7FFF, 8'h00);

    // Largest accepted payload, filled exactly.
    repeat (4) put_report(ID_ROT, {$urandom, $urandom});
    put_report(ID_TS_A, {$urandom, $urandom});
    put_report(8'h33, '0);
    put_report(8'h44, '0);
    put_report(8'hFF, '0);
    ship(15'(MAX_PAYLOAD + 4), CHAN_B);

    // Reports on channels that are not parsed.
    payload.delete();
    put_report(ID_ROT, {$urandom, $urandom});
    ship(18, 8'h00);
    ship(18, 8'hFF);

    // Reports that do not fit, then an unknown id ahead of a report.
    payload.delete();
    payload.push_back(ID_ROT);
    repeat (12) payload.push_back(8'h00);
    ship(17, CHAN_A);
    payload.delete();
    payload.push_back(ID_ACC);
    repeat (8) payload.push_back(8'h00);
    ship(13, CHAN_B);
    payload.delete();
    put_report(8'h77, '0);
    put_report(ID_ACC, {$urandom, $urandom});
    ship(15, CHAN_A);

    // Timestamp skip running past the end of the packet.
    payload.delete();
    put_report(ID_GYR, {$urandom, $urandom});
    payload.push_back(ID_TS_B);
    payload.push_back(8'h12);
    payload.push_back(8'h34);
    ship(15'(payload.size() + 4), CHAN_A);

    // Stray beats with no packet open, then a packet cut short by a new one.
    send_loose(3);
    payload.delete();
    put_report(ID_ROT, {$urandom, $urandom});
    while (payload.size() > 7) void'(payload.pop_back());
    ship(18, CHAN_A);
    payload.delete();
    put_report(ID_ACC, {$urandom, $urandom});
    ship(14, CHAN_B);

    drain_results();
    flood_while_stalled();
    drain_results();

    stop_at = ITEMS;
    while (counted_bytes < stop_at) begin
      if ($urandom_range(0, 9) == 0) tx_gaps_on = !tx_gaps_on;
      random_packet();
      if (!mid_flood_done && counted_bytes > stop_at - ITEMS / 2) begin
        mid_flood_done = 1'b1;
        drain_results();
        flood_while_stalled();
      end
    end

    in_ch.valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (10) @(negedge clk);
    $display("Covered %0d packet bytes with random gaps and two long result stalls.",
             counted_bytes);
    $display("Checked %0d orientation, %0d motion and %0d rejection results.",
             orient_count, motion_count, reject_count);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule

// ===== sim.f =====
hdl/isrp_pkg.sv
hdl/isrp_in_if.sv
hdl/isrp_out_if.sv
hdl/isrp_front.sv
hdl/isrp_queue.sv
hdl/isrp_back.sv
hdl/imu_sensor_report_parser_unit.sv
hdl/isrp_checker.sv
dv/isrp_checker.sv
dv/testbench.sv
